// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== hdl/lfu_pkg.sv =====
package lfu_pkg;

    typedef enum logic [2:0] {
        ST_CACHE_HIT   = 3'd0,
        ST_FILLED      = 3'd1,
        ST_PROMOTED    = 3'd2,
        ST_HIST_HIT    = 3'd3,
        ST_HIST_NEW    = 3'd4,
        ST_HIST_FULL   = 3'd5,
        ST_LOOKUP_HIT  = 3'd6,
        ST_LOOKUP_MISS = 3'd7
    } status_t;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] key_tag;
        logic [31:0] body_handle;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  way;
        logic [31:0] handle_out;
        logic [31:0] evicted_tag;
    } rsp_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_WAYS,
        FSM_SCAN,
        FSM_CHECK,
        FSM_DONE
    } fsm_t;

endpackage

// ===== hdl/lfu_hist_mem.sv =====
// Single-port history memory of tag and count, with registered read.
module lfu_hist_mem #(
    parameter int DEPTH = 1024,
    parameter int TAG_BITS = 32,
    parameter int COUNT_BITS = 16,
    parameter int ADDR_BITS = 10
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_BITS-1:0]  addr,
    input  logic [TAG_BITS-1:0]   wtag,
    input  logic [COUNT_BITS-1:0] wcount,
    output logic [TAG_BITS-1:0]   rtag,
    output logic [COUNT_BITS-1:0] rcount
);

    logic [TAG_BITS+COUNT_BITS-1:0] mem [DEPTH];

    // Read-first port; the controller never uses read data of a just-written entry.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= {wtag, wcount};
        end
        {rtag, rcount} <= mem[addr];
    end

endmodule

// ===== hdl/lfu_cache_with_history_unit.sv =====
// A cache hit, fill or lookup goes from idle through the way search to done.
// A history transaction scans up to fill_reg entries at one per cycle over the
// single memory port, then checks for a free entry unless a tag matches.
// Throughput: one transaction at a time; busy stays high until the result.
// Reset clears the way counts and the history fill count; no clearing pass.
// The result strobe lasts one cycle and cannot be stalled.
module lfu_cache_with_history_unit #(
    parameter int CACHE_WAYS = 3,
    parameter int HISTORY_DEPTH = 1024,
    parameter int TAG_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  lfu_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output lfu_pkg::rsp_t rsp
);

    localparam int WB = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
    localparam int AB = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FB = $clog2(HISTORY_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [COUNT_BITS-1:0] CONE = COUNT_BITS'(1);

    // Way state: small register file.
    logic [TAG_BITS-1:0]   way_tag_reg    [CACHE_WAYS];
    logic [31:0]           way_handle_reg [CACHE_WAYS];
    logic [COUNT_BITS-1:0] way_count_reg  [CACHE_WAYS];

    lfu_pkg::fsm_t   state_reg, state_next;
    logic            op_reg;
    logic [TAG_BITS-1:0] key_reg;
    logic [31:0]     body_reg;
    logic [FB-1:0]   fill_reg, fill_next;
    logic [FB-1:0]   idx_reg, idx_next;
    logic [WB-1:0]   least_reg, least_next;
    lfu_pkg::rsp_t   rsp_reg, rsp_next;
    logic            done_reg, done_next;

    logic                  mem_we;
    logic [AB-1:0]         mem_addr;
    logic [TAG_BITS-1:0]   mem_wtag, mem_rtag;
    logic [COUNT_BITS-1:0] mem_wcount, mem_rcount;

    // Way search results.
    logic            w_hit, w_empty;
    logic [WB-1:0]   w_hit_idx, w_empty_idx, w_least;
    logic [WB-1:0]   w_write_idx;
    logic            w_write;
    logic [TAG_BITS-1:0]   w_wtag;
    logic [COUNT_BITS-1:0] w_wcount;
    logic [31:0]     w_whandle;
    logic            w_whandle_en;
    logic [COUNT_BITS-1:0] inc_cnt;

    lfu_hist_mem #(
        .DEPTH(HISTORY_DEPTH), .TAG_BITS(TAG_BITS),
        .COUNT_BITS(COUNT_BITS), .ADDR_BITS(AB)
    ) u_mem (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wtag(mem_wtag),
        .wcount(mem_wcount), .rtag(mem_rtag), .rcount(mem_rcount)
    );

    // Ordered way search: first empty or match stops, least tracked before.
    always_comb
    begin
        logic stop;
        w_hit = 1'b0;
        w_empty = 1'b0;
        w_hit_idx = '0;
        w_empty_idx = '0;
        w_least = '0;
        stop = 1'b0;
        for (int i = 0; i < CACHE_WAYS; i++)
        begin
            if (!stop)
            begin
                if (way_count_reg[i] == '0)
                begin
                    w_empty = 1'b1;
                    w_empty_idx = WB'(i);
                    stop = 1'b1;
                end
                else if (way_tag_reg[i] == key_reg)
                begin
                    w_hit = 1'b1;
                    w_hit_idx = WB'(i);
                    stop = 1'b1;
                end
                else if (way_count_reg[i] < way_count_reg[w_least])
                begin
                    w_least = WB'(i);
                end
            end
        end
    end

    assign inc_cnt = (mem_rcount == CMAX) ? CMAX : mem_rcount + CONE;

    // Control sequencer.
    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        idx_next = idx_reg;
        least_next = least_reg;
        rsp_next = rsp_reg;
        done_next = 1'b0;
        mem_we = 1'b0;
        mem_addr = idx_reg[AB-1:0];
        mem_wtag = key_reg;
        mem_wcount = CONE;
        w_write = 1'b0;
        w_write_idx = '0;
        w_wtag = key_reg;
        w_wcount = CONE;
        w_whandle = body_reg;
        w_whandle_en = 1'b0;
        case (state_reg)
            lfu_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = lfu_pkg::FSM_WAYS;
                end
            end
            lfu_pkg::FSM_WAYS:
            begin
                rsp_next = '0;
                idx_next = '0;
                least_next = w_least;
                state_next = lfu_pkg::FSM_DONE;
                if (op_reg == lfu_pkg::OP_LOOKUP)
                begin
                    if (w_hit)
                    begin
                        rsp_next.status = lfu_pkg::ST_LOOKUP_HIT;
                        rsp_next.way = 2'(w_hit_idx);
                        rsp_next.handle_out = way_handle_reg[w_hit_idx];
                    end
                    else
                    begin
                        rsp_next.status = lfu_pkg::ST_LOOKUP_MISS;
                    end
                end
                else if (w_empty)
                begin
                    w_write = 1'b1;
                    w_write_idx = w_empty_idx;
                    w_whandle_en = 1'b1;
                    rsp_next.status = lfu_pkg::ST_FILLED;
                    rsp_next.way = 2'(w_empty_idx);
                end
                else if (w_hit)
                begin
                    w_write = 1'b1;
                    w_write_idx = w_hit_idx;
                    w_wtag = way_tag_reg[w_hit_idx];
                    w_wcount = (way_count_reg[w_hit_idx] == CMAX) ? CMAX
                             : way_count_reg[w_hit_idx] + CONE;
                    rsp_next.status = lfu_pkg::ST_CACHE_HIT;
                    rsp_next.way = 2'(w_hit_idx);
                end
                else if (fill_reg == '0)
                begin
                    mem_addr = '0;
                    mem_we = 1'b1;
                    fill_next = fill_reg + FB'(1);
                    rsp_next.status = lfu_pkg::ST_HIST_NEW;
                end
                else
                begin
                    mem_addr = '0;
                    state_next = lfu_pkg::FSM_SCAN;
                end
            end
            lfu_pkg::FSM_SCAN:
            begin
                // Read data belongs to idx_reg; address runs one ahead.
                if (mem_rtag == key_reg)
                begin
                    mem_we = 1'b1;
                    rsp_next = '0;
                    state_next = lfu_pkg::FSM_DONE;
                    if (inc_cnt >= way_count_reg[least_reg])
                    begin
                        mem_wtag = way_tag_reg[least_reg];
                        mem_wcount = way_count_reg[least_reg];
                        w_write = 1'b1;
                        w_write_idx = least_reg;
                        w_wcount = inc_cnt;
                        w_whandle_en = 1'b1;
                        rsp_next.status = lfu_pkg::ST_PROMOTED;
                        rsp_next.way = 2'(least_reg);
                        rsp_next.evicted_tag = 32'(way_tag_reg[least_reg]);
                    end
                    else
                    begin
                        mem_wtag = key_reg;
                        mem_wcount = inc_cnt;
                        rsp_next.status = lfu_pkg::ST_HIST_HIT;
                    end
                end
                else if (idx_reg + FB'(1) == fill_reg)
                begin
                    state_next = lfu_pkg::FSM_CHECK;
                    idx_next = fill_reg;
                end
                else
                begin
                    idx_next = idx_reg + FB'(1);
                    mem_addr = idx_next[AB-1:0];
                end
            end
            lfu_pkg::FSM_CHECK:
            begin
                rsp_next = '0;
                state_next = lfu_pkg::FSM_DONE;
                if (fill_reg < FB'(HISTORY_DEPTH))
                begin
                    mem_addr = fill_reg[AB-1:0];
                    mem_we = 1'b1;
                    fill_next = fill_reg + FB'(1);
                    rsp_next.status = lfu_pkg::ST_HIST_NEW;
                end
                else
                begin
                    rsp_next.status = lfu_pkg::ST_HIST_FULL;
                end
            end
            lfu_pkg::FSM_DONE:
            begin
                done_next = 1'b1;
                state_next = lfu_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = lfu_pkg::FSM_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::FSM_IDLE;
            fill_reg <= '0;
            done_reg <= 1'b0;
            for (int i = 0; i < CACHE_WAYS; i++)
            begin
                way_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            done_reg <= done_next;
            if (w_write)
            begin
                way_count_reg[w_write_idx] <= w_wcount;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        least_reg <= least_next;
        rsp_reg <= rsp_next;
        if (state_reg == lfu_pkg::FSM_IDLE && start)
        begin
            op_reg <= req.opcode;
            key_reg <= TAG_BITS'(req.key_tag);
            body_reg <= req.body_handle;
        end
        if (w_write)
        begin
            way_tag_reg[w_write_idx] <= w_wtag;
            if (w_whandle_en)
            begin
                way_handle_reg[w_write_idx] <= w_whandle;
            end
        end
    end

    assign busy = (state_reg != lfu_pkg::FSM_IDLE);
    assign done = done_reg;
    assign rsp = rsp_reg;

endmodule

// ===== hdl/lfu_checker.sv =====
`include "assert_macros.svh"

// Port-level checks of the command handshake and result encoding.
module lfu_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input lfu_pkg::rsp_t rsp
);

    `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `CHK_IMPLY(a_done_ends, clk, rst_n, done, !busy)
    `CHK_NEXT(a_done_single, clk, rst_n, done, !done)
    `CHK_IMPLY(a_handle_zero, clk, rst_n, done && rsp.status != lfu_pkg::ST_LOOKUP_HIT, rsp.handle_out == '0)

endmodule

bind lfu_cache_with_history_unit lfu_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
